// ===== hw/rtl/tmm_pkg.sv =====
// Shared types and constants for the tilt motion monitor.
package tmm_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int WINDOW_DEPTH = 128;
  localparam int RING_AW      = $clog2(WINDOW_DEPTH);
  localparam int WARM_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_BITS + RING_AW + 1;
  localparam int RING_W       = 3 * SAMPLE_BITS;
  localparam int SQ_W         = 2 * SAMPLE_BITS - 1;  // largest square is 2^(2*SAMPLE_BITS-2)
  localparam int DZ_W         = SAMPLE_BITS + 1;
  localparam int DZSQ_W       = 2 * SAMPLE_BITS;
  localparam int UNEV_W       = DZSQ_W + 1;
  localparam int MAG_W        = SQ_W + 1;
  localparam int TOL_W        = 4;

  localparam logic signed [SAMPLE_BITS-1:0] GZ_RESET  = -10'sd210;
  localparam logic [TOL_W-1:0]              TOL_RESET = 4'd5;

  // register index codes
  localparam logic REG_GRAVITY_Z = 1'b0;
  localparam logic REG_TOL_SHIFT = 1'b1;

  typedef struct packed {
    logic                          full;
    logic signed [SUM_W-1:0]       sum_x;
    logic signed [SUM_W-1:0]       sum_y;
    logic signed [SUM_W-1:0]       sum_z;
  } tmm_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] gravity_z;
    logic [TOL_W-1:0]              tol_shift;
  } tmm_cfg_t;

endpackage

// ===== hw/rtl/tmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tmm_queue.sv =====
// Small FIFO between the window front end and the detector back end.
module tmm_queue
  import tmm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tmm_item_t push_item,
  output logic      full,
  input  logic      pop,
  output tmm_item_t head,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tmm_item_t       store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tmm_front.sv =====
// Front end: takes samples, keeps the sample ring, warm-up count and window sums.
module tmm_front
  import tmm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_x,
  input  logic signed [SAMPLE_BITS-1:0] sample_y,
  input  logic signed [SAMPLE_BITS-1:0] sample_z,
  output logic                          push,
  output tmm_item_t                     push_item,
  input  logic                          q_full
);

  logic [RING_AW-1:0]            wr_pos_r;
  logic [WARM_W-1:0]             warm_r;
  logic                          b_valid_r;
  logic [RING_AW-1:0]            b_addr_r;
  logic                          b_old_ok_r;
  logic                          b_full_r;
  logic signed [SAMPLE_BITS-1:0] b_x_r;
  logic signed [SAMPLE_BITS-1:0] b_y_r;
  logic signed [SAMPLE_BITS-1:0] b_z_r;
  logic signed [SUM_W-1:0]       sum_x_r;
  logic signed [SUM_W-1:0]       sum_y_r;
  logic signed [SUM_W-1:0]       sum_z_r;
  logic signed [SUM_W-1:0]       sum_x_nxt;
  logic signed [SUM_W-1:0]       sum_y_nxt;
  logic signed [SUM_W-1:0]       sum_z_nxt;
  logic signed [SAMPLE_BITS-1:0] old_x;
  logic signed [SAMPLE_BITS-1:0] old_y;
  logic signed [SAMPLE_BITS-1:0] old_z;
  logic [RING_W-1:0]             ring_rdata;
  logic                          accept;
  logic                          b_fire;

  assign b_fire   = b_valid_r && !q_full;
  assign in_ready = !b_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  // ring slots are filled in order, so before the first wrap the slot
  // being overwritten has never been written and counts as zero
  tmm_ram #(
    .WIDTH (RING_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_addr_r),
    .wdata ({b_z_r, b_y_r, b_x_r}),
    .re    (accept),
    .raddr (wr_pos_r),
    .rdata (ring_rdata)
  );

  always_comb begin
    old_x = '0;
    old_y = '0;
    old_z = '0;
    if (b_old_ok_r) begin
      old_x = ring_rdata[SAMPLE_BITS-1:0];
      old_y = ring_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      old_z = ring_rdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    end
    sum_x_nxt = sum_x_r + SUM_W'(b_x_r) - SUM_W'(old_x);
    sum_y_nxt = sum_y_r + SUM_W'(b_y_r) - SUM_W'(old_y);
    sum_z_nxt = sum_z_r + SUM_W'(b_z_r) - SUM_W'(old_z);
  end

  assign push            = b_fire;
  assign push_item.full  = b_full_r;
  assign push_item.sum_x = sum_x_nxt;
  assign push_item.sum_y = sum_y_nxt;
  assign push_item.sum_z = sum_z_nxt;

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr_r   <= wr_pos_r;
      b_old_ok_r <= (warm_r == WARM_W'(WINDOW_DEPTH));
      b_full_r   <= (warm_r >= WARM_W'(WINDOW_DEPTH - 1));
      b_x_r      <= sample_x;
      b_y_r      <= sample_y;
      b_z_r      <= sample_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      wr_pos_r  <= '0;
      warm_r    <= '0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_z_r   <= '0;
    end else begin
      if (accept) begin
        b_valid_r <= 1'b1;
        wr_pos_r  <= wr_pos_r + 1'b1;
        if (warm_r != WARM_W'(WINDOW_DEPTH)) begin
          warm_r <= warm_r + 1'b1;
        end
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire) begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        sum_z_r <= sum_z_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/tmm_back.sv =====
// Back end: averages, squares, tilt and magnitude checks, result register.
module tmm_back
  import tmm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmm_cfg_t                      cfg,
  input  tmm_item_t                     head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          unstable,
  output logic                          uneven,
  output logic                          window_full,
  output logic signed [SAMPLE_BITS-1:0] average_x,
  output logic signed [SAMPLE_BITS-1:0] average_y,
  output logic signed [SAMPLE_BITS-1:0] average_z
);

  localparam logic [SUM_W-1:0] BIAS = SUM_W'(WINDOW_DEPTH - 1);

  // stage 1: averages
  logic                          v1_r;
  logic                          full1_r;
  logic signed [SAMPLE_BITS-1:0] ax1_r;
  logic signed [SAMPLE_BITS-1:0] ay1_r;
  logic signed [SAMPLE_BITS-1:0] az1_r;
  // stage 2: squares
  logic                          v2_r;
  logic                          full2_r;
  logic signed [SAMPLE_BITS-1:0] ax2_r;
  logic signed [SAMPLE_BITS-1:0] ay2_r;
  logic signed [SAMPLE_BITS-1:0] az2_r;
  logic [SQ_W-1:0]               sqx_r;
  logic [SQ_W-1:0]               sqy_r;
  logic [SQ_W-1:0]               sqz_r;
  logic [DZSQ_W-1:0]             sqdz_r;
  logic [SQ_W-1:0]               g2_2_r;
  // stage 3: sums
  logic                          v3_r;
  logic                          full3_r;
  logic signed [SAMPLE_BITS-1:0] ax3_r;
  logic signed [SAMPLE_BITS-1:0] ay3_r;
  logic signed [SAMPLE_BITS-1:0] az3_r;
  logic [UNEV_W-1:0]             tilt_r;
  logic [MAG_W-1:0]              mag_r;
  logic [SQ_W-1:0]               g2_3_r;
  logic [SQ_W-1:0]               tol_r;
  // result register
  logic                          out_valid_r;
  logic                          unstable_r;
  logic                          uneven_r;
  logic                          full_o_r;
  logic signed [SAMPLE_BITS-1:0] ax_o_r;
  logic signed [SAMPLE_BITS-1:0] ay_o_r;
  logic signed [SAMPLE_BITS-1:0] az_o_r;

  logic                          adv_o;
  logic                          rdy3;
  logic                          rdy2;
  logic                          rdy1;
  logic [SUM_W-1:0]              bx;
  logic [SUM_W-1:0]              by;
  logic [SUM_W-1:0]              bz;
  logic signed [DZ_W-1:0]        dz;
  logic signed [DZSQ_W-1:0]      px;
  logic signed [DZSQ_W-1:0]      py;
  logic signed [DZSQ_W-1:0]      pz;
  logic signed [DZSQ_W-1:0]      pg;
  logic signed [DZSQ_W+1:0]      pdz;
  logic [MAG_W-1:0]              g2_ext;
  logic [MAG_W-1:0]              diff;
  logic                          tilt_hit;

  assign adv_o = !out_valid_r || out_ready;
  assign rdy3  = !v3_r || adv_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign pop   = rdy1 && !q_empty;

  // divide by the window depth, rounding toward zero
  assign bx = head.sum_x[SUM_W-1] ? $unsigned(head.sum_x) + BIAS : $unsigned(head.sum_x);
  assign by = head.sum_y[SUM_W-1] ? $unsigned(head.sum_y) + BIAS : $unsigned(head.sum_y);
  assign bz = head.sum_z[SUM_W-1] ? $unsigned(head.sum_z) + BIAS : $unsigned(head.sum_z);

  assign dz  = DZ_W'(az1_r) - DZ_W'(cfg.gravity_z);
  assign px  = DZSQ_W'(ax1_r) * DZSQ_W'(ax1_r);
  assign py  = DZSQ_W'(ay1_r) * DZSQ_W'(ay1_r);
  assign pz  = DZSQ_W'(az1_r) * DZSQ_W'(az1_r);
  assign pg  = DZSQ_W'(cfg.gravity_z) * DZSQ_W'(cfg.gravity_z);
  assign pdz = (DZSQ_W + 2)'(dz) * (DZSQ_W + 2)'(dz);

  assign g2_ext   = MAG_W'(g2_3_r);
  assign diff     = (mag_r >= g2_ext) ? mag_r - g2_ext : g2_ext - mag_r;
  assign tilt_hit = tilt_r > UNEV_W'(g2_3_r);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      full1_r <= head.full;
      ax1_r   <= bx[RING_AW+SAMPLE_BITS-1:RING_AW];
      ay1_r   <= by[RING_AW+SAMPLE_BITS-1:RING_AW];
      az1_r   <= bz[RING_AW+SAMPLE_BITS-1:RING_AW];
    end
    if (rdy2) begin
      full2_r <= full1_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      az2_r   <= az1_r;
      sqx_r   <= px[SQ_W-1:0];
      sqy_r   <= py[SQ_W-1:0];
      sqz_r   <= pz[SQ_W-1:0];
      sqdz_r  <= pdz[DZSQ_W-1:0];
      g2_2_r  <= pg[SQ_W-1:0];
    end
    if (rdy3) begin
      full3_r <= full2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      az3_r   <= az2_r;
      tilt_r  <= UNEV_W'(sqx_r) + UNEV_W'(sqy_r) + UNEV_W'(sqdz_r);
      mag_r   <= MAG_W'(sqx_r) + MAG_W'(sqy_r) + MAG_W'(sqz_r);
      g2_3_r  <= g2_2_r;
      tol_r   <= g2_2_r >> cfg.tol_shift;
    end
    if (adv_o) begin
      uneven_r   <= tilt_hit;
      unstable_r <= full3_r && (diff > MAG_W'(tol_r) || tilt_hit);
      full_o_r   <= full3_r;
      ax_o_r     <= ax3_r;
      ay_o_r     <= ay3_r;
      az_o_r     <= az3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= !q_empty;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (adv_o) begin
        out_valid_r <= v3_r;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign unstable    = unstable_r;
  assign uneven      = uneven_r;
  assign window_full = full_o_r;
  assign average_x   = ax_o_r;
  assign average_y   = ay_o_r;
  assign average_z   = az_o_r;

endmodule

// ===== hw/rtl/tilt_motion_monitor.sv =====
// Top level of the tilt motion monitor: register port and front/queue/back wiring.
//
//  channel  dir  transfer when              payload
//  in_      in   in_tvalid & in_tready      one x/y/z accelerometer sample
//  out_     out  out_tvalid & out_tready    flags and windowed averages
//  cfg_     in   psel & penable & pwrite    gravity z reference, tolerance shift
//
// Throughput is one sample per clock while the result side does not stall; the
// ring read-modify-write in the front end and the squaring stage in the back end
// both take one item per cycle. A sample passes the front-end register, the queue,
// the averaging, squaring and summing stages and the result register, in that order.
// Reset is synchronous; the ring needs no clearing pass because slots are
// written in order and the warm-up count masks slots not yet written.
// A stall on the result side fills the back pipeline, then the queue, then the
// front-end sample register, and only then drops in_tready.
module tilt_motion_monitor
  import tmm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [9:0] sample_x, [19:10] sample_y, [29:20] sample_z
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [0] unstable, [1] uneven, [2] window_full,
                                   // [12:3] average_x, [22:13] average_y,
                                   // [32:23] average_z
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tmm_cfg_t                      cfg_r;
  logic                          cfg_wr;
  logic                          reg_idx;
  logic                          push;
  tmm_item_t                     push_item;
  logic                          q_full;
  logic                          q_empty;
  logic                          pop;
  tmm_item_t                     head;
  logic                          unstable;
  logic                          uneven;
  logic                          window_full;
  logic signed [SAMPLE_BITS-1:0] average_x;
  logic signed [SAMPLE_BITS-1:0] average_y;
  logic signed [SAMPLE_BITS-1:0] average_z;

  // registers sit at byte offsets 0 and 4
  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_z <= GZ_RESET;
      cfg_r.tol_shift <= TOL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRAVITY_Z: cfg_r.gravity_z <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_TOL_SHIFT: cfg_r.tol_shift <= cfg_pwdata[TOL_W-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRAVITY_Z: cfg_prdata = 32'(cfg_r.gravity_z);
      REG_TOL_SHIFT: cfg_prdata = 32'(cfg_r.tol_shift);
      default:       cfg_prdata = '0;
    endcase
  end

  tmm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sample_x  (in_tdata[SAMPLE_BITS-1:0]),
    .sample_y  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .sample_z  (in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  tmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  tmm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .unstable    (unstable),
    .uneven      (uneven),
    .window_full (window_full),
    .average_x   (average_x),
    .average_y   (average_y),
    .average_z   (average_z)
  );

  assign out_tdata = {7'd0, average_z, average_y, average_x, window_full, uneven, unstable};

endmodule
